// ===== rtl/core/sfr_crc_pkg.sv =====
`timescale 1ns / 1ps

package sfr_crc_pkg;

   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  HEAD_RESET    = 8'hAA;
   localparam logic [7:0]  TAIL_RESET    = 8'h55;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd255;
   localparam logic [7:0]  MIN_FRAME_LEN = 8'd5;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_CRC  = 2'd1,
      ST_LEN  = 2'd2,
      ST_TAIL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAD    = 2'd0,
      CSR_TAIL    = 2'd1,
      CSR_MAX_LEN = 2'd2
   } csr_index_type;

   // Framing settings as seen by the framer.
   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] tail_byte;
      logic [7:0] max_frame_len;
   } cfg_type;

   // One result word.
   typedef struct packed {
      status_type frame_status;
      logic       frame_end;
      logic       frame_start;
      logic [7:0] frame_byte;
   } rsp_item_type;

   // CRC-16/MODBUS update over one byte, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/sfr_framer.sv =====
`timescale 1ns / 1ps

module sfr_framer
   import sfr_crc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  logic [7:0]   rx_byte,
   input  cfg_type      cfg,
   output logic         res_valid,
   output rsp_item_type res_item
);

   logic        in_frame_ff,     in_frame_in;
   logic [7:0]  byte_index_ff,   byte_index_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [15:0] running_crc_ff,  running_crc_in;
   logic [7:0]  crc_low_seen_ff, crc_low_seen_in;
   logic        crc_ok_ff,       crc_ok_in;
   logic [7:0]  len_m3;
   logic [7:0]  len_m2;
   logic [15:0] crc_next;

   // Frame length is at least five whenever these are used, so no wrap.
   assign len_m3   = frame_length_ff - 8'd3;
   assign len_m2   = frame_length_ff - 8'd2;
   assign crc_next = crc_byte(in_frame_ff ? running_crc_ff : CRC_INIT, rx_byte);

   always_comb begin
      in_frame_in     = in_frame_ff;
      byte_index_in   = byte_index_ff;
      frame_length_in = frame_length_ff;
      running_crc_in  = running_crc_ff;
      crc_low_seen_in = crc_low_seen_ff;
      crc_ok_in       = crc_ok_ff;
      res_valid       = 1'b0;
      res_item        = '{frame_status: ST_OK, frame_end: 1'b0, frame_start: 1'b0,
                          frame_byte: rx_byte};
      if (step_en) begin
         if (!in_frame_ff) begin
            if (rx_byte == cfg.head_byte) begin
               in_frame_in          = 1'b1;
               byte_index_in        = 8'd1;
               running_crc_in       = crc_next;
               crc_low_seen_in      = 8'h00;
               crc_ok_in            = 1'b0;
               res_valid            = 1'b1;
               res_item.frame_start = 1'b1;
            end
         end else begin
            res_valid = 1'b1;
            priority if (byte_index_ff == 8'd1) begin
               frame_length_in = rx_byte;
               if (rx_byte < MIN_FRAME_LEN || rx_byte > cfg.max_frame_len) begin
                  res_item.frame_end    = 1'b1;
                  res_item.frame_status = ST_LEN;
                  in_frame_in           = 1'b0;
                  byte_index_in         = 8'd0;
                  running_crc_in        = CRC_INIT;
                  crc_low_seen_in       = 8'h00;
                  crc_ok_in             = 1'b0;
               end else begin
                  running_crc_in = crc_next;
                  byte_index_in  = 8'd2;
               end
            end else if (byte_index_ff < len_m3) begin
               running_crc_in = crc_next;
               byte_index_in  = byte_index_ff + 8'd1;
            end else if (byte_index_ff == len_m3) begin
               crc_low_seen_in = rx_byte;
               byte_index_in   = byte_index_ff + 8'd1;
            end else if (byte_index_ff == len_m2) begin
               crc_ok_in     = (crc_low_seen_ff == running_crc_ff[7:0]) &&
                               (rx_byte == running_crc_ff[15:8]);
               byte_index_in = byte_index_ff + 8'd1;
            end else begin
               // Tail position: a wrong tail outranks a bad CRC.
               res_item.frame_end = 1'b1;
               if (rx_byte != cfg.tail_byte) begin
                  res_item.frame_status = ST_TAIL;
               end else if (!crc_ok_ff) begin
                  res_item.frame_status = ST_CRC;
               end else begin
                  res_item.frame_status = ST_OK;
               end
               in_frame_in     = 1'b0;
               byte_index_in   = 8'd0;
               running_crc_in  = CRC_INIT;
               crc_low_seen_in = 8'h00;
               crc_ok_in       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         byte_index_ff   <= 8'd0;
         frame_length_ff <= 8'd0;
         running_crc_ff  <= CRC_INIT;
         crc_low_seen_ff <= 8'h00;
         crc_ok_ff       <= 1'b0;
      end else begin
         in_frame_ff     <= in_frame_in;
         byte_index_ff   <= byte_index_in;
         frame_length_ff <= frame_length_in;
         running_crc_ff  <= running_crc_in;
         crc_low_seen_ff <= crc_low_seen_in;
         crc_ok_ff       <= crc_ok_in;
      end
   end

endmodule

// ===== rtl/core/serial_frame_receiver_crc16.sv =====
`timescale 1ns / 1ps

// Serial frame receiver with a CRC-16/MODBUS check. Received bytes arrive one
// word at a time on the req_ stream. Bytes are dropped until one matches the
// head byte; the byte after it gives the frame length, counted from head to
// tail. The frame is head, length, payload, CRC low, CRC high and tail, and
// framing follows the length alone, so head or tail values inside a frame are
// plain data. Every frame byte is echoed on the rsp_ stream with a start flag
// on the head and tlast on the final word, which also carries the status: ok,
// CRC error, length error (length below five or above the maximum, reported
// on the length byte itself) or tail error, the last taking precedence over a
// CRC error. The block takes one byte every clock cycle while the output
// register is free or being read, and each byte's result is in that register
// in the cycle after it is accepted; the byte-wide CRC update is combinational.
// The three settings are written through the csr_ port, which is always
// ready, and should be changed only while no frame is in progress.

module serial_frame_receiver_crc16
   import sfr_crc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] rx_byte
   // Result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] frame_byte
   output logic       rsp_tlast,    // frame_end
   output logic [2:0] rsp_tuser,    // [0] frame_start, [2:1] frame_status
   // Settings write port
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   cfg_type      cfg_ff;
   logic         req_accept;
   logic         step_valid;
   rsp_item_type step_item;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   // The output register frees up in the same cycle its word is taken, so a
   // new byte can enter every cycle while the output word is being taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte     <= HEAD_RESET;
         cfg_ff.tail_byte     <= TAIL_RESET;
         cfg_ff.max_frame_len <= MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAD:    cfg_ff.head_byte     <= csr_wdata;
            CSR_TAIL:    cfg_ff.tail_byte     <= csr_wdata;
            CSR_MAX_LEN: cfg_ff.max_frame_len <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfr_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_accept),
      .rx_byte   (req_tdata),
      .cfg       (cfg_ff),
      .res_valid (step_valid),
      .res_item  (step_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= step_valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_item_ff <= step_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff.frame_byte;
   assign rsp_tlast  = rsp_item_ff.frame_end;
   assign rsp_tuser  = {rsp_item_ff.frame_status, rsp_item_ff.frame_start};

   // A head word can never also close its frame.
   a_start_not_end : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item_ff.frame_start |-> !rsp_item_ff.frame_end)
      else $error("frame start and frame end on the same word");

   // Only the closing word of a frame carries a non-ok status.
   a_status_on_end : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_item_ff.frame_end |-> rsp_item_ff.frame_status == ST_OK)
      else $error("status reported on a word that does not end a frame");

   // A start word echoes the configured head byte.
   a_start_is_head : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item_ff.frame_start |-> rsp_item_ff.frame_byte == cfg_ff.head_byte)
      else $error("frame start on a byte other than the head byte");

   // A byte that produces a result is visible in the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      req_accept && step_valid |=> rsp_valid_ff)
      else $error("result of an accepted byte was lost");

endmodule
